// ===== rtl/h264fu_pkg.sv =====
// Shared constants and types for the H.264 FU-A packetizer.
// No dependencies.
`default_nettype none

package h264fu_pkg;

    localparam int unsigned LEN_W = 16;
    localparam int unsigned MTU_W = 16;

    localparam logic [MTU_W-1:0] MTU_RESET = 16'd1400;
    localparam logic [MTU_W-1:0] MTU_MIN   = 16'd3;
    localparam logic [MTU_W-1:0] FU_OVERHEAD = 16'd2;

    localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
    localparam logic [7:0] NAL_NRI_MASK  = 8'h60;
    localparam logic [7:0] FU_A_TYPE     = 8'd28;

    // output phase of an item that opens a fragment
    localparam logic [1:0] PH_IND  = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_start;
        logic       packet_end;
        logic       rtp_marker;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/h264_fu_a_packetizer.sv =====
// H.264 RTP packetizer: single NAL unit packets and FU-A fragmentation.
// Uses h264fu_pkg.
`default_nettype none

// One NAL byte per input word, NAL length on every word. A byte is taken into
// an item register and its results go out through an output register, and the
// block streams 1 byte per cycle while the output is not stalled. A byte that
// opens an FU-A fragment yields 3 output words (FU indicator, FU header,
// data) and holds the input until all three are out; the header byte of a
// fragmented NAL yields no word and does not wait on the output. Packet start,
// end and the marker travel on tuser[0], tlast and tuser[1].
module h264_fu_a_packetizer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,    // mtu
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [7:0] data_byte, [23:8] nal_length
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic             m_axis_tlast,   // packet_end
    output logic [1:0]       m_axis_tuser    // [0] packet_start, [1] rtp_marker
);

    localparam int unsigned LW = h264fu_pkg::LEN_W;
    localparam int unsigned MW = h264fu_pkg::MTU_W;

    logic [MW-1:0] mtu_reg;

    logic          item_valid_reg;
    logic [7:0]    item_byte_reg;
    logic [LW-1:0] item_len_reg;
    logic [1:0]    phase_reg;

    logic [LW-1:0] idx_reg;
    logic [LW-1:0] fill_reg;
    logic          mode_reg;
    logic          first_reg;
    logic [7:0]    ind_reg;
    logic [4:0]    type_reg;

    logic                m_valid_reg;
    h264fu_pkg::result_t m_res_reg;
    h264fu_pkg::result_t res_next;

    logic [MW-1:0] mtu_eff;
    logic [MW-1:0] frag;
    logic [LW-1:0] len_eff;
    logic [LW:0]   idx_inc;
    logic [LW:0]   fill_inc;
    logic [LW:0]   room;
    logic [LW-1:0] remaining;
    logic          idx_zero;
    logic          last_byte;
    logic          long_nal;
    logic          mode_eff;
    logic          final_pkt;
    logic          ends;
    logic          opens;
    logic          no_result;
    logic          last_phase;
    logic          out_free;
    logic          step;
    logic          done;
    logic [7:0]    fu_hdr;

    always_comb begin
        mtu_eff   = (mtu_reg < h264fu_pkg::MTU_MIN) ? h264fu_pkg::MTU_MIN : mtu_reg;
        frag      = mtu_eff - h264fu_pkg::FU_OVERHEAD;
        len_eff   = (item_len_reg == '0) ? LW'(1) : item_len_reg;
        idx_zero  = (idx_reg == '0);
        idx_inc   = {1'b0, idx_reg} + (LW+1)'(1);
        last_byte = (idx_inc >= {1'b0, len_eff});
        long_nal  = (len_eff > LW'(mtu_eff));
        mode_eff  = idx_zero ? long_nal : mode_reg;
        remaining = last_byte ? LW'(1) : (len_eff - idx_reg);
        room      = {1'b0, LW'(frag)} - {1'b0, fill_reg};
        // fill beyond a shrunken fragment size counts as final
        final_pkt = room[LW] | (remaining <= room[LW-1:0]);
        fill_inc  = {1'b0, fill_reg} + (LW+1)'(1);
        ends      = last_byte | (fill_inc >= {1'b0, LW'(frag)});
        opens     = mode_eff & ~idx_zero & (fill_reg == '0);
        no_result = mode_eff & idx_zero;
        fu_hdr    = {first_reg, final_pkt, 1'b0, type_reg};

        last_phase = no_result | ~opens | (phase_reg == h264fu_pkg::PH_DATA);
        out_free   = ~m_valid_reg | m_axis_tready;
        step       = item_valid_reg & (no_result | out_free);
        done       = step & last_phase;

        if (!mode_eff) begin
            res_next = '{out_byte: item_byte_reg, packet_start: idx_zero,
                         packet_end: last_byte, rtp_marker: 1'b1};
        end else if (opens && phase_reg == h264fu_pkg::PH_IND) begin
            res_next = '{out_byte: ind_reg, packet_start: 1'b1,
                         packet_end: 1'b0, rtp_marker: final_pkt};
        end else if (opens && phase_reg == h264fu_pkg::PH_HDR) begin
            res_next = '{out_byte: fu_hdr, packet_start: 1'b0,
                         packet_end: 1'b0, rtp_marker: final_pkt};
        end else begin
            res_next = '{out_byte: item_byte_reg, packet_start: 1'b0,
                         packet_end: ends, rtp_marker: final_pkt};
        end
    end

    assign s_axis_tready = ~item_valid_reg | done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mtu_reg <= h264fu_pkg::MTU_RESET;
        end else if (cfg_wr_en) begin
            mtu_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            phase_reg      <= h264fu_pkg::PH_IND;
        end else begin
            if (s_axis_tready) begin
                item_valid_reg <= s_axis_tvalid;
            end
            if (done) begin
                phase_reg <= h264fu_pkg::PH_IND;
            end else if (step) begin
                phase_reg <= phase_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            item_byte_reg <= s_axis_tdata[7:0];
            item_len_reg  <= s_axis_tdata[23:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            fill_reg  <= '0;
            mode_reg  <= 1'b0;
            first_reg <= 1'b1;
            ind_reg   <= '0;
            type_reg  <= '0;
        end else if (done) begin
            if (last_byte) begin
                idx_reg   <= '0;
                fill_reg  <= '0;
                mode_reg  <= 1'b0;
                first_reg <= 1'b1;
            end else begin
                idx_reg <= idx_inc[LW-1:0];
                if (idx_zero) begin
                    mode_reg  <= long_nal;
                    fill_reg  <= '0;
                    first_reg <= 1'b1;
                    if (long_nal) begin
                        type_reg <= 5'(item_byte_reg & h264fu_pkg::NAL_TYPE_MASK);
                        ind_reg  <= (item_byte_reg & h264fu_pkg::NAL_NRI_MASK)
                                    | h264fu_pkg::FU_A_TYPE;
                    end
                end else if (mode_reg) begin
                    fill_reg <= ends ? '0 : fill_inc[LW-1:0];
                    if (opens) begin
                        first_reg <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step && !no_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && !no_result) begin
            m_res_reg <= res_next;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_res_reg.out_byte;
    assign m_axis_tlast    = m_res_reg.packet_end;
    assign m_axis_tuser[0] = m_res_reg.packet_start;
    assign m_axis_tuser[1] = m_res_reg.rtp_marker;

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3)
        else $error("phase counter out of range");

    a_phase_only_on_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != h264fu_pkg::PH_IND) |-> (item_valid_reg && mode_reg && !idx_zero))
        else $error("FU phase advanced outside a fragment opening");

    a_ind_then_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && opens && phase_reg == h264fu_pkg::PH_IND)
            |=> (phase_reg == h264fu_pkg::PH_HDR && m_valid_reg && item_valid_reg))
        else $error("FU indicator not followed by FU header");

endmodule

`default_nettype wire
